FILE: rtl/urx_pkg.sv
// shared types and constants for the uart receiver with timeout
`timescale 1ns / 1ps

package urx_pkg;

    // field widths
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned TIMER_W   = 17;
    localparam int unsigned BIDX_W    = 4;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;

    // protocol constants
    localparam int unsigned DATA_BITS = 8;
    localparam logic [PERIOD_W-1:0] MIN_BIT_PERIOD = 16'd4;

    // register reset values
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST  = 16'd104;
    localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST = 16'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HUNT = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    // live register values seen by the core
    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic [PERIOD_W-1:0] poll_period;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic [DATA_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

FILE: rtl/urx_ifs.sv
// valid/ready channel interfaces for ticks, results and register writes
`timescale 1ns / 1ps

interface urx_tick_if;
    logic                         valid;
    logic                         ready;
    logic                         arm;
    logic [urx_pkg::LIMIT_W-1:0]  timeout_polls;
    logic                         rx_line;

    modport source (output valid, arm, timeout_polls, rx_line, input ready);
    modport sink   (input valid, arm, timeout_polls, rx_line, output ready);
endinterface

interface urx_result_if;
    logic                          valid;
    logic                          ready;
    logic [urx_pkg::DATA_W-1:0]    data_byte;
    logic [urx_pkg::STATUS_W-1:0]  status;

    modport source (output valid, data_byte, status, input ready);
    modport sink   (input valid, data_byte, status, output ready);
endinterface

interface urx_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [urx_pkg::CFG_IDX_W-1:0]  index;
    logic [urx_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/urx_cfg_regs.sv
// configuration registers: bit period and poll period
`timescale 1ns / 1ps

module urx_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    urx_cfg_if.sink     cfg,
    output urx_pkg::cfg_t cfg_vals
);
    import urx_pkg::*;

    logic [PERIOD_W-1:0] bit_period_reg;
    logic [PERIOD_W-1:0] poll_period_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register file, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= BIT_PERIOD_RST;
            poll_period_reg <= POLL_PERIOD_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_BIT_PERIOD)
            begin
                bit_period_reg <= cfg.data;
            end
            else if (cfg.index == REG_POLL_PERIOD)
            begin
                poll_period_reg <= cfg.data;
            end
        end
    end

    assign cfg_vals.bit_period  = bit_period_reg;
    assign cfg_vals.poll_period = poll_period_reg;

endmodule

FILE: rtl/urx_core.sv
// receive state machine: one tick step per accepted word
`timescale 1ns / 1ps

module urx_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         arm,
    input  logic [urx_pkg::LIMIT_W-1:0]  timeout_polls,
    input  logic                         rx_line,
    input  urx_pkg::cfg_t                cfg_vals,
    output logic                         res_valid,
    output urx_pkg::res_t                res,
    output logic                         busy
);
    import urx_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [LIMIT_W-1:0]  polls_reg, polls_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [BIDX_W-1:0]   bidx_reg, bidx_next;
    logic [DATA_W-1:0]   shift_reg, shift_next;

    logic [PERIOD_W-1:0] bp_eff;
    logic [PERIOD_W-1:0] pp_eff;
    logic [LIMIT_W-1:0]  polls_inc;
    logic [BIDX_W-1:0]   bidx_inc;

    // clamp short periods
    assign bp_eff    = (cfg_vals.bit_period < MIN_BIT_PERIOD) ? MIN_BIT_PERIOD
                                                              : cfg_vals.bit_period;
    assign pp_eff    = (cfg_vals.poll_period == '0) ? PERIOD_W'(1) : cfg_vals.poll_period;
    assign polls_inc = polls_reg + LIMIT_W'(1);
    assign bidx_inc  = bidx_reg + BIDX_W'(1);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            polls_reg <= '0;
            limit_reg <= '0;
            bidx_reg  <= '0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            polls_reg <= polls_next;
            limit_reg <= limit_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
        end
    end

    // next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        polls_next    = polls_reg;
        limit_next    = limit_reg;
        bidx_next     = bidx_reg;
        shift_next    = shift_reg;
        res_valid     = 1'b0;
        res.data_byte = '0;
        res.status    = ST_OK;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (arm)
                    begin
                        if (timeout_polls == '0)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TIMEOUT;
                            timer_next = '0;
                        end
                        else
                        begin
                            limit_next = timeout_polls;
                            polls_next = '0;
                            timer_next = '0;
                            bidx_next  = '0;
                            shift_next = '0;
                            phase_next = PH_HUNT;
                        end
                    end
                end
                PH_HUNT:
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                    else if (!rx_line)
                    begin
                        // start bit seen, first sample at 1.25 bit periods
                        timer_next = {1'b0, bp_eff} + {3'b000, bp_eff[PERIOD_W-1:2]}
                                     - TIMER_W'(1);
                        bidx_next  = '0;
                        shift_next = '0;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        polls_next = polls_inc;
                        if (polls_inc >= limit_reg)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TIMEOUT;
                            phase_next = PH_IDLE;
                            timer_next = '0;
                        end
                        else
                        begin
                            timer_next = {1'b0, pp_eff} - TIMER_W'(1);
                        end
                    end
                end
                PH_DATA:
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                    else
                    begin
                        // lsb first sample
                        shift_next = shift_reg | (DATA_W'(rx_line) << bidx_reg[2:0]);
                        bidx_next  = bidx_inc;
                        timer_next = {1'b0, bp_eff} - TIMER_W'(1);
                        if (bidx_inc >= BIDX_W'(DATA_BITS))
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_STOP:
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        if (rx_line)
                        begin
                            res.data_byte = shift_reg;
                            res.status    = ST_OK;
                        end
                        else
                        begin
                            res.status = ST_FRAME;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign busy = (phase_reg != PH_IDLE);

endmodule

FILE: rtl/uart_receiver_with_timeout.sv
// uart 8n1 receiver with bounded start-bit hunt
// throughput: one tick word per cycle while the result side takes words
// the tick is held in an input register and stepped through the state machine
// into an output register; ticks stall only when a result waits unread
// reset: asynchronous active low, idle phase, bit period 104, poll period 1
`timescale 1ns / 1ps

module uart_receiver_with_timeout (
    input  logic          clk,
    input  logic          rst_n,
    urx_tick_if.sink      tick,
    urx_result_if.source  result,
    urx_cfg_if.sink       cfg
);
    import urx_pkg::*;

    logic                s1_valid_reg;
    logic                s1_arm_reg;
    logic [LIMIT_W-1:0]  s1_limit_reg;
    logic                s1_rx_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic                s1_adv;
    logic                core_res_valid;
    res_t                core_res;
    logic                core_busy;
    cfg_t                cfg_vals;

    // configuration registers
    urx_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_vals (cfg_vals)
    );

    // step the held tick when the output register has room
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || s1_adv;

    urx_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_adv),
        .arm           (s1_arm_reg),
        .timeout_polls (s1_limit_reg),
        .rx_line       (s1_rx_reg),
        .cfg_vals      (cfg_vals),
        .res_valid     (core_res_valid),
        .res           (core_res),
        .busy          (core_busy)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_arm_reg   <= tick.arm;
            s1_limit_reg <= tick.timeout_polls;
            s1_rx_reg    <= tick.rx_line;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= core_res_valid;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && core_res_valid)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.data_byte = out_res_reg.data_byte;
    assign result.status    = out_res_reg.status;

    // a result always ends the attempt
    a_result_ends_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && core_res_valid) |=> !core_busy)
        else $error("receiver still busy after a result word");

    // only an ok word carries data
    a_data_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |-> (result.data_byte == '0))
        else $error("error result word with nonzero data");

    // an empty input register never stalls ticks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> tick.ready)
        else $error("tick side stalled with empty input register");

    // a result word is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> ($stable(out_res_reg) && out_valid_reg))
        else $error("waiting result word overwritten");

endmodule
